[hdl/ebs_pkg.sv]
// ebs_pkg: shared types and constants for the evicting bounded stack.
// Holds the command, response and record structs, and the stack depth.
// No dependencies.
`timescale 1ns / 1ps

package ebs_pkg;

    localparam int DEPTH = 8;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0]
    {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_CLEAR = 2'd3
    } ebs_op_t;

    typedef enum logic [2:0]
    {
        ST_DONE    = 3'd0,
        ST_POPPED  = 3'd1,
        ST_PEEKED  = 3'd2,
        ST_EVICTED = 3'd3,
        ST_EMPTY   = 3'd4
    } ebs_status_t;

    typedef struct packed
    {
        ebs_op_t            cmd;
        logic [63:0]        entry_name;
        logic [7:0]         entry_kind;
        logic signed [31:0] entry_value;
    } ebs_cmd_t;

    typedef struct packed
    {
        ebs_status_t        status;
        logic [63:0]        out_name;
        logic [7:0]         out_kind;
        logic signed [31:0] out_value;
    } ebs_rsp_t;

    typedef struct packed
    {
        logic [63:0]        name;
        logic [7:0]         kind;
        logic signed [31:0] value;
    } ebs_rec_t;

    // shift control broadcast to every cell
    typedef struct packed
    {
        logic push;
        logic pop;
    } ebs_shift_t;

endpackage

[hdl/evicting_bounded_stack.sv]
// evicting_bounded_stack: top level, fill count, command decode and response register.
// Instantiates a row of ebs_cell slots; depends on ebs_pkg.
`timescale 1ns / 1ps

// A LIFO of ebs_pkg::DEPTH records kept in a row of cells, top of stack in cell 0.
// Push shifts the row down by one and a pop shifts it up. One command item is taken per
// cycle while responses are taken, and its response appears in the response register on
// the next cycle. Push into a full stack returns the bottom record (last cell) with
// status evicted. The command side stalls only while a response waits and is itself
// stalled.

module evicting_bounded_stack
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  ebs_pkg::ebs_cmd_t cmd_item,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output ebs_pkg::ebs_rsp_t rsp_item
);

    logic [ebs_pkg::CNT_W-1:0] count_reg;
    logic [ebs_pkg::CNT_W-1:0] count_next;
    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    ebs_pkg::ebs_rsp_t         rsp_item_reg;
    ebs_pkg::ebs_rsp_t         rsp_item_next;

    logic                      accept;
    logic                      empty;
    logic                      full;
    ebs_pkg::ebs_shift_t       shift;
    ebs_pkg::ebs_rec_t         new_rec;
    ebs_pkg::ebs_rec_t         cell_rec [ebs_pkg::DEPTH];

    assign cmd_stall = rsp_valid_reg & rsp_stall;
    assign accept    = cmd_valid & ~cmd_stall;
    assign empty     = (count_reg == '0);
    assign full      = (count_reg == ebs_pkg::CNT_W'(ebs_pkg::DEPTH));

    assign shift.push = accept & (cmd_item.cmd == ebs_pkg::CMD_PUSH);
    assign shift.pop  = accept & (cmd_item.cmd == ebs_pkg::CMD_POP) & ~empty;

    assign new_rec.name  = cmd_item.entry_name;
    assign new_rec.kind  = cmd_item.entry_kind;
    assign new_rec.value = cmd_item.entry_value;

    genvar g;
    generate
        for (g = 0; g < ebs_pkg::DEPTH; g++)
        begin : g_cell
            ebs_cell u_cell
            (
                .clk   (clk),
                .shift (shift),
                .upper ((g == 0) ? new_rec : cell_rec[(g == 0) ? 0 : g - 1]),
                .lower ((g == ebs_pkg::DEPTH - 1) ? cell_rec[g]
                        : cell_rec[(g == ebs_pkg::DEPTH - 1) ? g : g + 1]),
                .rec   (cell_rec[g])
            );
        end
    endgenerate

    always_comb
    begin
        count_next    = count_reg;
        rsp_item_next = rsp_item_reg;
        if (accept)
        begin
            rsp_item_next = '0;
            unique case (cmd_item.cmd)
                ebs_pkg::CMD_PUSH:
                begin
                    if (full)
                    begin
                        rsp_item_next.status    = ebs_pkg::ST_EVICTED;
                        rsp_item_next.out_name  = cell_rec[ebs_pkg::DEPTH-1].name;
                        rsp_item_next.out_kind  = cell_rec[ebs_pkg::DEPTH-1].kind;
                        rsp_item_next.out_value = cell_rec[ebs_pkg::DEPTH-1].value;
                    end
                    else
                    begin
                        count_next           = count_reg + ebs_pkg::CNT_W'(1);
                        rsp_item_next.status = ebs_pkg::ST_DONE;
                    end
                end
                ebs_pkg::CMD_POP, ebs_pkg::CMD_PEEK:
                begin
                    if (empty)
                    begin
                        rsp_item_next.status = ebs_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        rsp_item_next.status    = (cmd_item.cmd == ebs_pkg::CMD_POP)
                                                  ? ebs_pkg::ST_POPPED : ebs_pkg::ST_PEEKED;
                        rsp_item_next.out_name  = cell_rec[0].name;
                        rsp_item_next.out_kind  = cell_rec[0].kind;
                        rsp_item_next.out_value = cell_rec[0].value;
                        if (cmd_item.cmd == ebs_pkg::CMD_POP)
                        begin
                            count_next = count_reg - ebs_pkg::CNT_W'(1);
                        end
                    end
                end
                ebs_pkg::CMD_CLEAR:
                begin
                    count_next           = '0;
                    rsp_item_next.status = ebs_pkg::ST_DONE;
                end
                default:
                begin
                    rsp_item_next.status = ebs_pkg::ST_DONE;
                end
            endcase
        end
    end

    assign rsp_valid_next = accept | (rsp_valid_reg & rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_item_reg <= rsp_item_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

    a_evict_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        (shift.push && full) |=> (rsp_item_reg.status == ebs_pkg::ST_EVICTED))
        else $error("push into full stack did not evict");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        shift.pop |=> (count_reg == $past(count_reg) - ebs_pkg::CNT_W'(1)))
        else $error("pop did not decrement fill count");

    a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd_item.cmd == ebs_pkg::CMD_CLEAR) |=> (count_reg == '0))
        else $error("clear did not empty the stack");

endmodule

[hdl/ebs_cell.sv]
// ebs_cell: one stack slot of the cell row.
// Takes the record above on push, the record below on pop, else holds.
// Depends on ebs_pkg.
`timescale 1ns / 1ps

module ebs_cell
(
    input  logic              clk,
    input  ebs_pkg::ebs_shift_t shift,
    input  ebs_pkg::ebs_rec_t upper,
    input  ebs_pkg::ebs_rec_t lower,
    output ebs_pkg::ebs_rec_t rec
);

    ebs_pkg::ebs_rec_t rec_reg;
    ebs_pkg::ebs_rec_t rec_next;

    always_comb
    begin
        priority if (shift.push)
        begin
            rec_next = upper;
        end
        else if (shift.pop)
        begin
            rec_next = lower;
        end
        else
        begin
            rec_next = rec_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec = rec_reg;

endmodule

[verif/ebs_checker.sv]
// ebs_checker: watches the command and response channels of the evicting bounded stack,
// predicts each response from its own copy of the stack and compares field by field.
// Depends on ebs_pkg.
`timescale 1ns / 1ps

module ebs_checker
    import ebs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    input  logic     cmd_stall,
    input  ebs_cmd_t cmd_item,
    input  logic     rsp_valid,
    input  logic     rsp_stall,
    input  ebs_rsp_t rsp_item,
    output int       fail_count,
    output int       pending
);

    ebs_rec_t stack_mem [DEPTH];
    int       depth_used = 0;
    ebs_rsp_t expected_rsp [$];
    ebs_rsp_t want;
    int       errors = 0;
    int       queued = 0;

    assign fail_count = errors;
    assign pending    = queued;

    // index 0 is the oldest record
    function automatic ebs_rsp_t stack_response(input ebs_cmd_t c);
        ebs_rsp_t r;
        ebs_rec_t fresh;
        r = '0;
        r.status = ST_DONE;
        fresh.name  = c.entry_name;
        fresh.kind  = c.entry_kind;
        fresh.value = c.entry_value;
        case (c.cmd)
            CMD_PUSH:
            begin
                if (depth_used == DEPTH)
                begin
                    r.status    = ST_EVICTED;
                    r.out_name  = stack_mem[0].name;
                    r.out_kind  = stack_mem[0].kind;
                    r.out_value = stack_mem[0].value;
                    for (int i = 0; i < DEPTH - 1; i++)
                        stack_mem[i] = stack_mem[i + 1];
                    stack_mem[DEPTH - 1] = fresh;
                end
                else
                begin
                    stack_mem[depth_used] = fresh;
                    depth_used++;
                end
            end
            CMD_POP, CMD_PEEK:
            begin
                if (depth_used == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.status    = (c.cmd == CMD_POP) ? ST_POPPED : ST_PEEKED;
                    r.out_name  = stack_mem[depth_used - 1].name;
                    r.out_kind  = stack_mem[depth_used - 1].kind;
                    r.out_value = stack_mem[depth_used - 1].value;
                    if (c.cmd == CMD_POP)
                        depth_used--;
                end
            end
            default:
                depth_used = 0;
        endcase
        return r;
    endfunction

    task automatic field_check(input string field, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (exp_v !== got_v)
        begin
            errors++;
            if (errors <= 10)
                $display("%0t mismatch on %s: expected %h, got %h", $realtime, field,
                         exp_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_rsp.delete();
            depth_used = 0;
            queued     = 0;
        end
        else
        begin
            // response first: the item taken at this edge answers on a later cycle
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t response with nothing outstanding: %h", $realtime,
                                 rsp_item);
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    field_check("status", 64'(want.status), 64'(rsp_item.status));
                    field_check("out_name", want.out_name, rsp_item.out_name);
                    field_check("out_kind", 64'(want.out_kind), 64'(rsp_item.out_kind));
                    field_check("out_value", 64'(unsigned'(want.out_value)),
                                64'(unsigned'(rsp_item.out_value)));
                end
            end
            if (cmd_valid && !cmd_stall)
                expected_rsp.push_back(stack_response(cmd_item));
            queued = expected_rsp.size();
        end
    end

endmodule

[verif/testbench.sv]
// testbench: drives commands into the evicting bounded stack with bursty pacing and a
// stalling response side; ebs_checker does the prediction. Depends on ebs_pkg, the block
// and ebs_checker.
`timescale 1ns / 1ps

module testbench;
    import ebs_pkg::*;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     cmd_valid;
    logic     cmd_stall;
    ebs_cmd_t cmd_item;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    ebs_rsp_t rsp_item;
    int       fail_count;
    int       pending;
    int       stall_mode = 0;
    int       stall_left = 0;

    always #1 clk = ~clk;

    evicting_bounded_stack dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

    ebs_checker stack_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_item   (cmd_item),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_item   (rsp_item),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // response side stalls in modes that are picked at random and change over time
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 96);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 3) == 0);
            2:       rsp_stall <= ($urandom_range(0, 9) < 6);
            default: rsp_stall <= ($urandom_range(0, 7) == 0) ? ~rsp_stall : rsp_stall;
        endcase
    end

    function automatic ebs_cmd_t command(input ebs_op_t op, input logic [63:0] nm,
                                         input logic [7:0] kd,
                                         input logic signed [31:0] vl);
        ebs_cmd_t c;
        c.cmd         = op;
        c.entry_name  = nm;
        c.entry_kind  = kd;
        c.entry_value = vl;
        return c;
    endfunction

    function automatic ebs_cmd_t random_command(input int push_pct);
        ebs_cmd_t c;
        int       pick;
        pick = $urandom_range(0, 99);
        c.entry_name  = {$urandom, $urandom};
        c.entry_kind  = 8'($urandom);
        c.entry_value = $urandom;
        case ($urandom_range(0, 15))
            0: c.entry_name = '0;
            1: c.entry_name = '1;
            2: c.entry_kind = '0;
            3: c.entry_kind = '1;
            4: c.entry_value = 32'sh8000_0000;
            5: c.entry_value = 32'sh7fff_ffff;
            default: ;
        endcase
        if (pick < 2)
            c.cmd = CMD_CLEAR;
        else if (pick < push_pct)
            c.cmd = CMD_PUSH;
        else if (pick % 3 == 0)
            c.cmd = CMD_PEEK;
        else
            c.cmd = CMD_POP;
        return c;
    endfunction

    task automatic send(input ebs_cmd_t c);
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd_item  <= c;
        do
            @(posedge clk);
        while (cmd_stall);
    endtask

    task automatic pause(input int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            cmd_valid <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    initial
    begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int burst_left;
        int segment_left;
        int push_pct;
        burst_left   = 0;
        segment_left = 0;
        push_pct     = 50;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd_item  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty errors, extremes of each field
        send(command(CMD_POP, '0, '0, '0));
        send(command(CMD_PEEK, '0, '0, '0));
        send(command(CMD_PUSH, '0, 8'h00, 32'sh8000_0000));
        send(command(CMD_PUSH, '1, 8'hff, 32'sh7fff_ffff));
        send(command(CMD_PEEK, '0, '0, '0));
        send(command(CMD_POP, '0, '0, '0));
        send(command(CMD_POP, '0, '0, '0));
        send(command(CMD_POP, '0, '0, '0));
        // fill, then overflow so the two oldest are evicted
        for (int i = 0; i < DEPTH + 2; i++)
            send(command(CMD_PUSH, {$urandom, $urandom}, 8'(i + 8'h41), $urandom));
        send(command(CMD_PEEK, '0, '0, '0));
        send(command(CMD_POP, '0, '0, '0));
        send(command(CMD_CLEAR, '1, '1, -1));
        send(command(CMD_PEEK, '0, '0, '0));
        send(command(CMD_POP, '0, '0, '0));
        send(command(CMD_PUSH, 64'h0123_4567_89ab_cdef, 8'h5a, -1));
        send(command(CMD_POP, '0, '0, '0));
        pause(3);

        for (int n = 0; n < 1600; n++)
        begin
            if (segment_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       push_pct = 85;
                    1:       push_pct = 60;
                    2:       push_pct = 40;
                    default: push_pct = 15;
                endcase
                segment_left = $urandom_range(40, 120);
            end
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                if ($urandom_range(0, 2) != 0)
                    pause($urandom_range(1, 6));
            end
            send(random_command(push_pct));
            segment_left--;
            burst_left--;
        end
        @(negedge clk);
        cmd_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
